FILE: sv/prpu_pkg.sv
// shared types and constants of the planar rigid pose unit
// operation kinds, cordic gain and the arctangent table
// no dependencies
package prpu_pkg;

   typedef enum logic [1:0] {
      KIND_LOAD    = 2'd0,
      KIND_APPLY   = 2'd1,
      KIND_COMPOSE = 2'd2,
      KIND_INVERT  = 2'd3
   } kind_type;

   // converged cordic gain scaled by 2^30
   localparam longint GAIN_Q30 = 64'sd652032875;

   localparam int ATAN_IDX_W = 5;

   // arctangent of 2^-i in units of 2^32 per turn
   function automatic logic signed [31:0] atan_of(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [31:0] val;
      case (idx)
         5'd0:  val = 32'sd536870912;
         5'd1:  val = 32'sd316933406;
         5'd2:  val = 32'sd167458907;
         5'd3:  val = 32'sd85004756;
         5'd4:  val = 32'sd42667331;
         5'd5:  val = 32'sd21354465;
         5'd6:  val = 32'sd10679838;
         5'd7:  val = 32'sd5340245;
         5'd8:  val = 32'sd2670163;
         5'd9:  val = 32'sd1335087;
         5'd10: val = 32'sd667544;
         5'd11: val = 32'sd333772;
         5'd12: val = 32'sd166886;
         5'd13: val = 32'sd83443;
         5'd14: val = 32'sd41722;
         5'd15: val = 32'sd20861;
         5'd16: val = 32'sd10430;
         5'd17: val = 32'sd5215;
         5'd18: val = 32'sd2608;
         5'd19: val = 32'sd1304;
         5'd20: val = 32'sd652;
         5'd21: val = 32'sd326;
         5'd22: val = 32'sd163;
         5'd23: val = 32'sd81;
         default: val = 32'sd0;
      endcase
      return val;
   endfunction

endpackage

FILE: sv/prpu_cordic.sv
// iterative rotation-mode cordic: one micro-rotation per cycle
// produces sin and cos of a 16-bit binary angle scaled by 2^FRAC_BITS
// depends on prpu_pkg
module prpu_cordic
   import prpu_pkg::*;
#(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16,
   parameter int CW           = FRAC_BITS + 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [15:0]          angle,
   output logic                 done,
   output logic signed [CW-1:0] sin_val,
   output logic signed [CW-1:0] cos_val
);

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam int ZW     = 34;
   localparam logic signed [CW-1:0] X_INIT =
      CW'((GAIN_Q30 + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 flip_ff, flip_in;

   logic [31:0]          a_full;
   logic                 a_flip;
   logic signed [CW-1:0] dx, dy;
   logic signed [31:0]   atan_val;

   always_comb begin
      a_full = {angle, 16'd0};
      // second and third quadrant: turn by half a turn, negate at the end
      a_flip = (angle[15:14] == 2'b01) || (angle[15:14] == 2'b10);
      if (a_flip) begin
         a_full[31] = ~a_full[31];
      end
      dx       = y_ff >>> step_ff;
      dy       = x_ff >>> step_ff;
      atan_val = atan_of(ATAN_IDX_W'(step_ff));

      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      flip_in = flip_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = X_INIT;
         y_in    = '0;
         z_in    = ZW'(signed'(a_full));
         step_in = '0;
         busy_in = 1'b1;
         flip_in = a_flip;
      end else if (busy_ff) begin
         if (!z_ff[ZW-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ZW'(atan_val);
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ZW'(atan_val);
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign done    = done_ff;
   assign cos_val = flip_ff ? -x_ff : x_ff;
   assign sin_val = flip_ff ? -y_ff : y_ff;

endmodule

FILE: sv/prpu_mac.sv
// shared multiplier and accumulator for the 2x2 rotation plus translation
// four products over one multiplier, rounded and offset in turn
// depends on prpu_pkg
module prpu_mac
   import prpu_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int CW        = FRAC_BITS + 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [31:0]   u,
   input  logic signed [31:0]   v,
   input  logic signed [CW-1:0] sin_val,
   input  logic signed [CW-1:0] cos_val,
   input  logic [31:0]          tx,
   input  logic [31:0]          ty,
   output logic                 done,
   output logic [31:0]          out_x,
   output logic [31:0]          out_y
);

   localparam int PW = 32 + CW;
   localparam int AW = PW + 1;
   localparam logic signed [AW-1:0] HALF = AW'(longint'(1) << (FRAC_BITS - 1));

   logic [2:0]           phase_ff, phase_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic [31:0]          ox_ff, ox_in, oy_ff, oy_in;

   logic signed [31:0]   mul_a;
   logic signed [CW-1:0] mul_b;
   logic signed [AW-1:0] rnd_sum;
   logic [31:0]          rnd_val;

   always_comb begin
      // products in order: u*c, v*s, u*s, v*c
      mul_a   = phase_ff[0] ? v : u;
      mul_b   = (phase_ff == 3'd0 || phase_ff == 3'd3) ? cos_val : sin_val;
      rnd_sum = acc_ff + HALF;
      rnd_val = rnd_sum[FRAC_BITS +: 32];

      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      prod_in  = PW'(mul_a) * PW'(mul_b);
      acc_in   = acc_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = '0;
      end else if (busy_ff) begin
         phase_in = phase_ff + 1'b1;
         case (phase_ff)
            3'd1: acc_in = AW'(prod_ff);
            3'd2: acc_in = acc_ff - AW'(prod_ff);
            3'd3: begin
               ox_in  = rnd_val + tx;
               acc_in = AW'(prod_ff);
            end
            3'd4: acc_in = acc_ff + AW'(prod_ff);
            3'd5: begin
               oy_in   = rnd_val + ty;
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
   end

   assign done  = done_ff;
   assign out_x = ox_ff;
   assign out_y = oy_ff;

endmodule

FILE: sv/planar_rigid_pose_unit.sv
// Planar rigid pose unit: holds one SE(2) pose (Q16.16 translation, 16-bit binary angle)
// and runs load, apply, compose or invert on each request transaction, one at a time.
// A load goes from acceptance straight to the done state. The other operations first run
// CORDIC_STEPS cordic micro-rotations, then start the multiplier, run six multiply-accumulate
// phases for the four products, see the multiplier finish and move to the done state. From
// the done state the result is loaded into the result register once that register is free.
// The request side is ready again in the cycle in which the result appears, so a new
// transaction is taken only after the previous result has been registered.
// The request side is not ready while an operation is in flight; a finished result
// waits in the output register without holding up acceptance of the next transaction.
// Depends on prpu_pkg, prpu_cordic and prpu_mac.
module planar_rigid_pose_unit
   import prpu_pkg::*;
#(
   parameter int FRAC_BITS    = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // arg_x[31:0], arg_y[63:32], arg_angle[79:64]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // res_x[31:0], res_y[63:32], res_angle[79:64]
);

   localparam int CW = FRAC_BITS + 3;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ROT  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   kind_type    kind_ff, kind_in;
   logic [31:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic [15:0] pose_angle_ff, pose_angle_in;
   logic [31:0] u_ff, u_in, v_ff, v_in, tx_ff, tx_in, ty_ff, ty_in;
   logic [15:0] new_angle_ff, new_angle_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [79:0] rsp_data_ff, rsp_data_in;

   logic        accept;
   kind_type    req_kind;
   logic [31:0] arg_x, arg_y;
   logic [15:0] arg_angle;
   logic [15:0] rot_angle;
   logic        cordic_done, mac_done;
   logic signed [CW-1:0] sin_val, cos_val;
   logic [31:0] mac_x, mac_y;
   logic [31:0] fin_x, fin_y;

   assign req_kind  = kind_type'(req_tuser);
   assign arg_x     = req_tdata[31:0];
   assign arg_y     = req_tdata[63:32];
   assign arg_angle = req_tdata[79:64];
   assign accept    = req_tvalid && req_tready;
   assign rot_angle = (req_kind == KIND_INVERT) ? -pose_angle_ff : pose_angle_ff;

   prpu_cordic #(
      .FRAC_BITS    (FRAC_BITS),
      .CORDIC_STEPS (CORDIC_STEPS),
      .CW           (CW)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && (req_kind != KIND_LOAD)),
      .angle   (rot_angle),
      .done    (cordic_done),
      .sin_val (sin_val),
      .cos_val (cos_val)
   );

   prpu_mac #(
      .FRAC_BITS (FRAC_BITS),
      .CW        (CW)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   ((state_ff == ST_ROT) && cordic_done),
      .u       (u_ff),
      .v       (v_ff),
      .sin_val (sin_val),
      .cos_val (cos_val),
      .tx      (tx_ff),
      .ty      (ty_ff),
      .done    (mac_done),
      .out_x   (mac_x),
      .out_y   (mac_y)
   );

   always_comb begin
      fin_x = (kind_ff == KIND_LOAD) ? u_ff : mac_x;
      fin_y = (kind_ff == KIND_LOAD) ? v_ff : mac_y;

      state_in      = state_ff;
      kind_in       = kind_ff;
      pose_x_in     = pose_x_ff;
      pose_y_in     = pose_y_ff;
      pose_angle_in = pose_angle_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      new_angle_in  = new_angle_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_kind;
               u_in    = arg_x;
               v_in    = arg_y;
               tx_in   = pose_x_ff;
               ty_in   = pose_y_ff;
               case (req_kind)
                  KIND_LOAD:    new_angle_in = arg_angle;
                  KIND_APPLY:   new_angle_in = pose_angle_ff;
                  KIND_COMPOSE: new_angle_in = pose_angle_ff + arg_angle;
                  default: begin
                     // inverse: rotate the negated translation by the negated angle
                     new_angle_in = -pose_angle_ff;
                     u_in         = -pose_x_ff;
                     v_in         = -pose_y_ff;
                     tx_in        = '0;
                     ty_in        = '0;
                  end
               endcase
               state_in = (req_kind == KIND_LOAD) ? ST_DONE : ST_ROT;
            end
         end
         ST_ROT: begin
            if (cordic_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mac_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {new_angle_ff, fin_y, fin_x};
               if (kind_ff != KIND_APPLY) begin
                  pose_x_in     = fin_x;
                  pose_y_in     = fin_y;
                  pose_angle_in = new_angle_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         pose_angle_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pose_x_ff     <= pose_x_in;
         pose_y_ff     <= pose_y_in;
         pose_angle_ff <= pose_angle_in;
      end
      kind_ff      <= kind_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      tx_ff        <= tx_in;
      ty_ff        <= ty_in;
      new_angle_ff <= new_angle_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
